@@ rtl/sysex_file_deframer_unit_assert.svh @@
// Assertion macros shared by the deframer RTL.
`ifndef SYSEX_FILE_DEFRAMER_UNIT_ASSERT_SVH
`define SYSEX_FILE_DEFRAMER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted (reset is active low).
`define SFD_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("sysex deframer check failed");
// Clocked check that also holds during reset.
`define SFD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("sysex deframer check failed");
`else
`define SFD_ASSERT_CLK(label, clk, rst_n, prop)
`define SFD_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ rtl/sfd_pkg.sv @@
// Types and constants shared by the sysex file deframer modules.
package sfd_pkg;

    // Framing bytes and the status-byte marker.
    localparam logic [7:0] BYTE_SOF   = 8'hf0;
    localparam logic [7:0] BYTE_EOF   = 8'hf7;
    localparam int         STATUS_BIT = 7;

    // Parser phase codes; the codes above PH_FAILED are treated as failed.
    localparam logic [2:0] PH_FIRST   = 3'd0;
    localparam logic [2:0] PH_RAW     = 3'd1;
    localparam logic [2:0] PH_BETWEEN = 3'd2;
    localparam logic [2:0] PH_FRAME   = 3'd3;
    localparam logic [2:0] PH_FAILED  = 3'd4;

    // File status codes reported with the last beat.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_STATUS_BYTE = 3'd1;
    localparam logic [2:0] ST_EMPTY       = 3'd2;
    localparam logic [2:0] ST_STRAY       = 3'd3;
    localparam logic [2:0] ST_MISSING_EOF = 3'd4;
    localparam logic [2:0] ST_WRONG_COUNT = 3'd5;

    // Message count saturates at this value.
    localparam logic [1:0] COUNT_MAX = 2'd2;

    // Register address bits and index of require_single.
    localparam int         ADDR_W          = 3;
    localparam logic       REG_REQ_SINGLE  = 1'b0;

    // Stream widths.
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USER_W = 2;

    // Per-file parser state.
    typedef struct packed {
        logic [2:0] phase;
        logic       payload_seen;
        logic [1:0] msg_count;
        logic [2:0] err;
    } t_file_state;

    // One result item.
    typedef struct packed {
        logic [6:0] payload_byte;
        logic       byte_valid;
        logic       message_end;
        logic       done_res;
        logic [2:0] status;
    } t_result;

endpackage

@@ rtl/sysex_file_deframer_unit.sv @@
// Top level of the sysex file deframer: stream ports, register port, pipeline.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] file_byte, tlast = last
//  m_axis    out        tdata payload_byte/status, tuser flags, tlast = done_res
//  APB       in/out     register 0 (byte address 0): require_single
//
//  Each file byte gives one result beat, held first in the input register and
//  then in the result register. One byte is taken every cycle while the result
//  side keeps up; the parser state updates in one step between the two
//  registers. Reset clears the parser, the pipeline valids and require_single.
//  A stalled result holds both registers and input tready drops only when
//  both are full.
module sysex_file_deframer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sfd_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] file_byte
    input  logic                             s_axis_tlast,  // last
    // Output stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [sfd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [6:0] payload_byte,
                                                            // [9:7] status, rest zero
    output logic [sfd_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // [0] byte_valid,
                                                            // [1] message_end
    output logic                             m_axis_tlast,  // done_res
    // Register port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import sfd_pkg::*;

`include "sysex_file_deframer_unit_assert.svh"

    logic        r_require_single;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    t_file_state r_state;
    t_file_state n_state;
    t_result     n_out;
    logic        w_out_free;
    logic        w_advance;
    logic        w_take_in;
    logic        w_cfg_write;

    // Handshake steering between the two registers.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_take_in     = s_axis_tvalid && s_axis_tready;
    assign w_cfg_write   = psel && penable && pwrite && pready;

    // Register read path.
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_REQ_SINGLE) ? {31'd0, r_require_single} : 32'd0;

    // Parser step for the byte in the input register.
    sfd_step u_step (
        .i_state          (r_state),
        .i_byte           (r_in_byte),
        .i_last           (r_in_last),
        .i_require_single (r_require_single),
        .o_state          (n_state),
        .o_result         (n_out)
    );

    // Pipeline registers, parser state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_single <= 1'b0;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_state          <= '{phase: PH_FIRST, payload_seen: 1'b0,
                                  msg_count: 2'd0, err: ST_OK};
        end else begin
            if (w_cfg_write && paddr[ADDR_W-1] == REG_REQ_SINGLE) begin
                r_require_single <= pwdata[0];
            end
            if (w_take_in) begin
                r_in_byte <= s_axis_tdata;
                r_in_last <= s_axis_tlast;
            end
            if (w_take_in) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_state     <= n_state;
                r_out       <= n_out;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output beat packing.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.status, r_out.payload_byte};
    assign m_axis_tuser  = {r_out.message_end, r_out.byte_valid};
    assign m_axis_tlast  = r_out.done_res;

    // A failing file never shows data or a message end on its final beat.
    `SFD_ASSERT_CLK(a_err_no_data, i_clk, i_rst_n,
        (r_out_valid && r_out.status != ST_OK) |-> (!r_out.byte_valid && !r_out.message_end))
    // A status code appears only on the beat that closes the file.
    `SFD_ASSERT_CLK(a_status_on_last, i_clk, i_rst_n,
        (r_out_valid && !r_out.done_res) |-> (r_out.status == ST_OK))
    // A result that is not taken is still there in the next cycle.
    `SFD_ASSERT_CLK(a_hold_result, i_clk, i_rst_n,
        (r_out_valid && !m_axis_tready) |=> r_out_valid)

endmodule

@@ rtl/sfd_step.sv @@
// Next-state and result logic of the deframer for one file byte.
module sfd_step (
    input  sfd_pkg::t_file_state i_state,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic                 i_require_single,
    output sfd_pkg::t_file_state o_state,
    output sfd_pkg::t_result     o_result
);
    import sfd_pkg::*;

    always_comb begin
        logic [2:0] ph;
        logic       ps;
        logic [1:0] cnt;
        logic [2:0] err;
        logic       consumed;
        t_result    res;

        ph       = i_state.phase;
        ps       = i_state.payload_seen;
        cnt      = i_state.msg_count;
        err      = i_state.err;
        consumed = 1'b0;
        res      = '0;

        // The first byte picks framed or raw mode; an opening F0 is used up here.
        if (ph == PH_FIRST) begin
            if (i_byte == BYTE_SOF) begin
                ph       = PH_FRAME;
                ps       = 1'b0;
                consumed = 1'b1;
            end else begin
                ph = PH_RAW;
            end
        end

        // Per-phase handling of the byte.
        if (!consumed) begin
            case (ph)
                PH_RAW: begin
                    if (i_byte[STATUS_BIT]) begin
                        err = ST_STATUS_BYTE;
                        ph  = PH_FAILED;
                    end else begin
                        res.payload_byte = i_byte[6:0];
                        res.byte_valid   = 1'b1;
                        if (i_last) begin
                            res.message_end = 1'b1;
                            cnt             = 2'd1;
                        end
                    end
                end
                PH_BETWEEN: begin
                    if (i_byte != BYTE_SOF) begin
                        err = ST_STRAY;
                        ph  = PH_FAILED;
                    end else begin
                        ph = PH_FRAME;
                        ps = 1'b0;
                    end
                end
                PH_FRAME: begin
                    if (i_byte == BYTE_EOF) begin
                        if (err == ST_OK && !ps) begin
                            err = ST_EMPTY;
                        end
                        if (err != ST_OK) begin
                            ph = PH_FAILED;
                        end else begin
                            res.message_end = 1'b1;
                            if (cnt < COUNT_MAX) begin
                                cnt = cnt + 2'd1;
                            end
                            ph = PH_BETWEEN;
                        end
                    end else if (i_byte[STATUS_BIT]) begin
                        if (err == ST_OK) begin
                            err = ST_STATUS_BYTE;
                        end
                    end else if (err == ST_OK) begin
                        res.payload_byte = i_byte[6:0];
                        res.byte_valid   = 1'b1;
                        ps               = 1'b1;
                    end
                end
                default: begin
                    ph = PH_FAILED;
                end
            endcase
        end

        // File end: final checks, status report and state clear.
        if (i_last) begin
            if (ph == PH_FRAME) begin
                err = ST_MISSING_EOF;
            end else if (err == ST_OK && i_require_single && cnt != 2'd1) begin
                err = ST_WRONG_COUNT;
            end
            res.status   = err;
            res.done_res = 1'b1;
            if (err != ST_OK) begin
                res.payload_byte = '0;
                res.byte_valid   = 1'b0;
                res.message_end  = 1'b0;
            end
            ph  = PH_FIRST;
            ps  = 1'b0;
            cnt = '0;
            err = ST_OK;
        end

        o_state.phase        = ph;
        o_state.payload_seen = ps;
        o_state.msg_count    = cnt;
        o_state.err          = err;
        o_result             = res;
    end

endmodule

@@ test/sfd_checker.sv @@
// Checker for the sysex file deframer: predicts each result beat and compares it.
module sfd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream, observed.
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [sfd_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [7:0] file_byte
    input  logic                           i_s_tlast,   // last
    // Output stream, observed.
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [sfd_pkg::OUT_DATA_W-1:0] i_m_tdata,   // [6:0] payload_byte, [9:7] status
    input  logic [sfd_pkg::OUT_USER_W-1:0] i_m_tuser,   // [0] byte_valid, [1] message_end
    input  logic                           i_m_tlast,   // done_res
    // Register port, observed.
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [sfd_pkg::ADDR_W-1:0]     i_paddr,
    input  logic [31:0]                    i_pwdata,
    input  logic                           i_pready,
    // Results of the check.
    output int                             o_mismatch_count,
    output int                             o_results_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sfd_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_REQ_SINGLE = ADDR_W'(4 * REG_REQ_SINGLE);

    // Shadow copy of the register and of the per-file parser state.
    logic       req_single;
    logic [2:0] file_phase;
    logic       payload_seen;
    logic [1:0] msg_count;
    logic [2:0] file_err;

    t_result pending_results[$];
    int      beat_index;

    // Prints one line for a bad or unexpected beat and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: beat %0d: %s: got 0x%0h, expected 0x%0h",
                 $time, beat_index, what, got, want);
        o_mismatch_count++;
    endtask

    function automatic void clear_file();
        file_phase   = PH_FIRST;
        payload_seen = 1'b0;
        msg_count    = 2'd0;
        file_err     = ST_OK;
    endfunction

    // Advances the shadow parser by one file byte and returns the beat it yields.
    function automatic t_result deframe_byte(input logic [7:0] fbyte, input logic fin);
        t_result res;
        logic    sof_taken;
        res       = '0;
        sof_taken = 1'b0;

        // The first byte decides between framed and raw files.
        if (file_phase == PH_FIRST) begin
            if (fbyte == BYTE_SOF) begin
                file_phase   = PH_FRAME;
                payload_seen = 1'b0;
                sof_taken    = 1'b1;
            end else begin
                file_phase = PH_RAW;
            end
        end

        if (!sof_taken) begin
            case (file_phase)
                PH_RAW: begin
                    if (fbyte[STATUS_BIT]) begin
                        file_err   = ST_STATUS_BYTE;
                        file_phase = PH_FAILED;
                    end else begin
                        res.payload_byte = fbyte[6:0];
                        res.byte_valid   = 1'b1;
                        if (fin) begin
                            res.message_end = 1'b1;
                            msg_count       = 2'd1;
                        end
                    end
                end
                PH_BETWEEN: begin
                    if (fbyte != BYTE_SOF) begin
                        file_err   = ST_STRAY;
                        file_phase = PH_FAILED;
                    end else begin
                        file_phase   = PH_FRAME;
                        payload_seen = 1'b0;
                    end
                end
                PH_FRAME: begin
                    if (fbyte == BYTE_EOF) begin
                        if (file_err == ST_OK && !payload_seen)
                            file_err = ST_EMPTY;
                        if (file_err != ST_OK) begin
                            file_phase = PH_FAILED;
                        end else begin
                            res.message_end = 1'b1;
                            if (msg_count < COUNT_MAX)
                                msg_count = msg_count + 2'd1;
                            file_phase = PH_BETWEEN;
                        end
                    end else if (fbyte[STATUS_BIT]) begin
                        // A status byte inside a frame fails it, but the frame runs to F7.
                        if (file_err == ST_OK)
                            file_err = ST_STATUS_BYTE;
                    end else if (file_err == ST_OK) begin
                        res.payload_byte = fbyte[6:0];
                        res.byte_valid   = 1'b1;
                        payload_seen     = 1'b1;
                    end
                end
                default: file_phase = PH_FAILED;
            endcase
        end

        // The last byte reports the file status and rearms the parser.
        if (fin) begin
            if (file_phase == PH_FRAME)
                file_err = ST_MISSING_EOF;
            else if (file_err == ST_OK && req_single && msg_count != 2'd1)
                file_err = ST_WRONG_COUNT;
            res.status   = file_err;
            res.done_res = 1'b1;
            if (file_err != ST_OK) begin
                res.payload_byte = '0;
                res.byte_valid   = 1'b0;
                res.message_end  = 1'b0;
            end
            clear_file();
        end
        return res;
    endfunction

    // Register writes, input beats and result beats, all taken at the rising edge.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            req_single = 1'b0;
            clear_file();
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_REQ_SINGLE)
                req_single = i_pwdata[0];

            if (i_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("beat with no byte to answer", int'(i_m_tdata), 0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_m_tdata[6:0] !== want.payload_byte)
                        report_mismatch("payload_byte", int'(i_m_tdata[6:0]),
                                        int'(want.payload_byte));
                    if (i_m_tuser[0] !== want.byte_valid)
                        report_mismatch("byte_valid", int'(i_m_tuser[0]),
                                        int'(want.byte_valid));
                    if (i_m_tuser[1] !== want.message_end)
                        report_mismatch("message_end", int'(i_m_tuser[1]),
                                        int'(want.message_end));
                    if (i_m_tlast !== want.done_res)
                        report_mismatch("done_res", int'(i_m_tlast), int'(want.done_res));
                    if (i_m_tdata[9:7] !== want.status)
                        report_mismatch("status", int'(i_m_tdata[9:7]), int'(want.status));
                end
                beat_index++;
            end

            if (i_s_tvalid === 1'b1 && i_s_tready === 1'b1)
                pending_results.insert(pending_results.size(),
                                       deframe_byte(i_s_tdata[7:0], i_s_tlast));
        end
        o_results_pending = pending_results.size();
    end

endmodule

@@ test/tb_sysex_file_deframer_unit.sv @@
// Testbench top for the sysex file deframer: file stimulus, register writes, verdict.
module tb_sysex_file_deframer_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sfd_pkg::*;

    localparam int                CYCLE_LIMIT     = 500000;
    localparam int                PHASE_BYTES     = 480;
    localparam logic [ADDR_W-1:0] ADDR_REQ_SINGLE = ADDR_W'(4 * REG_REQ_SINGLE);

    typedef logic [7:0] t_byte_q[$];

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] file_byte
    logic                  s_axis_tlast;   // last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [6:0] payload_byte, [9:7] status
    logic [OUT_USER_W-1:0] m_axis_tuser;   // [0] byte_valid, [1] message_end
    logic                  m_axis_tlast;   // done_res
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int      mismatch_count;
    int      results_pending;
    int      cycle_count = 0;
    int      bytes_sent;
    bit      send_gaps;
    bit      recv_stalls;
    t_byte_q file_bytes;

    sysex_file_deframer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    sfd_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (s_axis_tvalid),
        .i_s_tready        (s_axis_tready),
        .i_s_tdata         (s_axis_tdata),
        .i_s_tlast         (s_axis_tlast),
        .i_m_tvalid        (m_axis_tvalid),
        .i_m_tready        (m_axis_tready),
        .i_m_tdata         (m_axis_tdata),
        .i_m_tuser         (m_axis_tuser),
        .i_m_tlast         (m_axis_tlast),
        .i_psel            (psel),
        .i_penable         (penable),
        .i_pwrite          (pwrite),
        .i_paddr           (paddr),
        .i_pwdata          (pwdata),
        .i_pready          (pready),
        .o_mismatch_count  (mismatch_count),
        .o_results_pending (results_pending)
    );

    always #5 i_clk = ~i_clk;

    // A run that hangs ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: ready in random stall bursts while stalls are enabled.
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (recv_stalls && $urandom_range(0, 9) == 0) begin
                stall_left    = $urandom_range(1, 18) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Register write with a setup phase and then an access phase, started at a falling edge.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One input beat, with an optional gap before it; returns at a falling edge.
    task automatic send_byte(input logic [7:0] fbyte, input logic fin);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= fbyte;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // Stops the input and waits until every result beat has come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (results_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Appends one byte to the file under construction.
    task automatic append_byte(input logic [7:0] fbyte);
        file_bytes.insert(file_bytes.size(), fbyte);
    endtask

    // One frame of 1 to 8 data bytes, now and then an empty one.
    task automatic add_frame();
        int len;
        len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
        append_byte(BYTE_SOF);
        repeat (len) append_byte(8'($urandom_range(0, 127)));
        append_byte(BYTE_EOF);
    endtask

    // Mostly well-formed files with random data; the rest noise or damaged frames.
    task automatic make_random_file();
        int kind;
        int pos;
        int len;
        file_bytes = {};
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            repeat (($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : 1) add_frame();
        end else if (kind < 8) begin
            repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 127)));
        end else if (kind == 8) begin
            len = $urandom_range(1, 10);
            append_byte($urandom_range(0, 1) ? BYTE_SOF : 8'($urandom_range(0, 255)));
            repeat (len - 1) begin
                case ($urandom_range(0, 3))
                    0:       append_byte(BYTE_EOF);
                    1:       append_byte(BYTE_SOF);
                    default: append_byte(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 2)) add_frame();
            pos = $urandom_range(0, file_bytes.size() - 1);
            case ($urandom_range(0, 2))
                0: file_bytes[pos] = 8'($urandom_range(0, 255));
                1: file_bytes.delete(file_bytes.size() - 1);
                default: file_bytes.insert(pos, 8'($urandom_range(128, 255)));
            endcase
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            make_random_file();
            send_file();
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        bytes_sent    = 0;
        send_gaps     = 1'b0;
        recv_stalls   = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed files with any message count allowed.
        apb_write(ADDR_REQ_SINGLE, 32'd0);
        file_bytes = {8'h00, 8'h7f};                           send_file();
        file_bytes = {8'hff};                                  send_file();
        file_bytes = {BYTE_SOF, 8'h00, 8'h7f, BYTE_EOF};       send_file();
        // Status bytes inside a frame, then the frame still closes.
        file_bytes = {BYTE_SOF, 8'h01, 8'h90, BYTE_SOF, BYTE_EOF}; send_file();
        // Status byte, then the file ends inside the frame.
        file_bytes = {BYTE_SOF, 8'h02, 8'h81};                 send_file();
        file_bytes = {BYTE_SOF, BYTE_EOF};                     send_file();
        file_bytes = {BYTE_SOF};                               send_file();
        file_bytes = {BYTE_SOF, 8'h03, BYTE_EOF, 8'h04};       send_file();
        drain();

        // Directed files where exactly one message is required.
        apb_write(ADDR_REQ_SINGLE, 32'd1);
        file_bytes = {BYTE_SOF, 8'h01, BYTE_EOF, BYTE_SOF, 8'h02, BYTE_EOF}; send_file();
        file_bytes = {8'h7f};                                  send_file();
        drain();

        // Random files under each setting, with gaps and stalls on both sides.
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        run_random(PHASE_BYTES);
        drain();
        apb_write(ADDR_REQ_SINGLE, 32'd0);
        run_random(PHASE_BYTES);
        drain();

        // Sender gaps only, so the result side runs at full rate.
        recv_stalls = 1'b0;
        run_random(PHASE_BYTES);
        drain();

        // Closing stretch at full rate on both sides.
        apb_write(ADDR_REQ_SINGLE, 32'd1);
        send_gaps = 1'b0;
        run_random(PHASE_BYTES);
        drain();
        repeat (10) @(negedge i_clk);

        if (mismatch_count == 0 && results_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
